/* rtl/irt_3pl_probability_information_core_macros.svh */
// assertion macros used by the irt3pl top-level rtl file
`ifndef IRT_3PL_PROBABILITY_INFORMATION_CORE_MACROS_SVH
`define IRT_3PL_PROBABILITY_INFORMATION_CORE_MACROS_SVH

// implication checked in the same cycle
`define IRT3PL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define IRT3PL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/irt3pl_pkg.sv */
// shared types, constants and sigmoid table for the irt3pl core
package irt3pl_pkg;

  localparam int SIG_DEPTH = 256;
  localparam int SIG_AW    = $clog2(SIG_DEPTH + 1);
  localparam int MAG_W     = 49;
  localparam int POS_W     = MAG_W + SIG_AW;
  localparam int IDX_W     = POS_W - 42;

  localparam int INFO_QW   = 24;
  localparam int DIV_NUM_W = 61;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_LAT   = INFO_QW + 1;

  localparam logic [15:0] SCALE_RESET = 16'd13943;
  localparam logic [23:0] INFO_MAX    = 24'hFFFFFF;
  localparam logic [16:0] Q16_ONE     = 17'h10000;

  typedef logic [16:0] sig_table_t [SIG_DEPTH + 1];

  typedef struct packed {
    logic signed [15:0] ability;
    logic [15:0]        discrimination;
    logic signed [15:0] difficulty;
    logic [15:0]        guessing;
  } item_t;

  typedef struct packed {
    logic [16:0] p17;
    logic [15:0] guessing;
    logic [31:0] da;
  } front_res_t;

  // unsigned shift-subtract quotient, only used while building the table
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f), f in [0,1] in q30, taylor series
  function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
    logic [63:0] term;
    longint      sum;
    term = 64'd1 << 30;
    sum  = longint'(64'd1 << 30);
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * f + (64'd1 << 29)) >> 30, 64'(k));
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum);
  endfunction

  // exp(-x), x in [0,16] in q30
  function automatic logic [63:0] exp_neg(logic [63:0] x);
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] e1;
    n  = x >> 30;
    e  = exp_neg_frac(x & ((64'd1 << 30) - 64'd1));
    e1 = exp_neg_frac(64'd1 << 30);
    for (int i = 0; i < 16; i++) begin
      if (64'(i) < n) e = (e * e1 + (64'd1 << 29)) >> 30;
    end
    return e;
  endfunction

  // logistic table, evaluated at elaboration
  function automatic sig_table_t build_sig_table();
    sig_table_t  t;
    logic [63:0] x;
    logic [63:0] den;
    for (int k = 0; k <= SIG_DEPTH; k++) begin
      x    = (64'(k) << 34) / 64'(SIG_DEPTH);
      den  = (64'd1 << 30) + exp_neg(x);
      t[k] = 17'(udiv64((64'd1 << 46) + (den >> 1), den));
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

/* rtl/irt3pl_in_if.sv */
// input request channel: one ability and one item
interface irt3pl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ability;
  logic [15:0]        discrimination;
  logic signed [15:0] difficulty;
  logic [15:0]        guessing;

  modport source (output valid, ability, discrimination, difficulty, guessing, input ready);
  modport sink   (input valid, ability, discrimination, difficulty, guessing, output ready);
endinterface

/* rtl/irt3pl_out_if.sv */
// result request channel: probability and information
interface irt3pl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;
  logic [23:0] information;
  logic        info_saturated;

  modport source (output valid, probability, information, info_saturated, input ready);
  modport sink   (input valid, probability, information, info_saturated, output ready);
endinterface

/* rtl/irt3pl_div.sv */
// pipelined restoring divider, one quotient bit per stage, overflow flag
module irt3pl_div
  import irt3pl_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [INFO_QW-1:0]   quot,
  output logic                 ovf
);

  logic [DIV_NUM_W-1:0] rem_r  [DIV_LAT];
  logic [DIV_DEN_W-1:0] den_r  [DIV_LAT];
  logic [INFO_QW-1:0]   quot_r [DIV_LAT];
  logic                 ovf_r  [DIV_LAT];

  logic [DIV_NUM_W-1:0] trial   [DIV_LAT];
  logic                 take    [DIV_LAT];
  logic [DIV_NUM_W-1:0] top_cmp;

  // per-stage shifted divisor and compare
  always_comb begin
    top_cmp = DIV_NUM_W'(den) << INFO_QW;
    trial[0] = '0;
    take[0]  = 1'b0;
    for (int j = 1; j < DIV_LAT; j++) begin
      trial[j] = DIV_NUM_W'(den_r[j-1]) << (INFO_QW - j);
      take[j]  = rem_r[j-1] >= trial[j];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      quot_r[0] <= '0;
      ovf_r[0]  <= num >= top_cmp;
      for (int j = 1; j < DIV_LAT; j++) begin
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        if (take[j]) begin
          rem_r[j]  <= rem_r[j-1] - trial[j];
          quot_r[j] <= quot_r[j-1] | (INFO_QW'(1) << (INFO_QW - j));
        end else begin
          rem_r[j]  <= rem_r[j-1];
          quot_r[j] <= quot_r[j-1];
        end
      end
    end
  end

  assign quot = quot_r[DIV_LAT-1];
  assign ovf  = ovf_r[DIV_LAT-1];

endmodule

/* rtl/irt3pl_front.sv */
// logit, interpolated sigmoid and probability, five register stages
module irt3pl_front
  import irt3pl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  item_t      item,
  input  logic [15:0] scale,
  output logic       res_valid,
  output front_res_t res
);

  logic [4:0]       v_r;
  logic [31:0]      da1_r, da2_r, da3_r, da4_r, da5_r;
  logic [15:0]      c1_r, c2_r, c3_r, c4_r, c5_r;
  logic             neg1_r, neg2_r, neg3_r;
  logic [16:0]      adt1_r;
  logic [MAG_W-1:0] mag2_r;
  logic [16:0]      lo3_r, hi3_r;
  logic [15:0]      frac3_r;
  logic [16:0]      s4_r;
  logic [16:0]      p5_r;

  logic [16:0]      dt;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic             at_edge;
  logic [SIG_AW-1:0] lo_sel, hi_sel;
  logic [33:0]      iprod;
  logic [18:0]      ssum;
  logic [16:0]      smag;
  logic [16:0]      one_c;
  logic [34:0]      pprod;
  logic [19:0]      psum;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // stage 1: scale times discrimination, ability minus difficulty
  assign dt = {item.ability[15], item.ability} - {item.difficulty[15], item.difficulty};
  always_ff @(posedge clk) begin
    if (en) begin
      da1_r  <= 32'(scale) * 32'(item.discrimination);
      neg1_r <= dt[16];
      adt1_r <= dt[16] ? (~dt + 17'd1) : dt;
      c1_r   <= item.guessing;
    end
  end

  // stage 2: logit magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r <= MAG_W'(adt1_r) * MAG_W'(da1_r);
      neg2_r <= neg1_r;
      da2_r  <= da1_r;
      c2_r   <= c1_r;
    end
  end

  // stage 3: table index and lookup
  always_comb begin
    pos     = POS_W'(mag2_r) * POS_W'(SIG_DEPTH);
    idx     = pos[POS_W-1:42];
    at_edge = idx >= IDX_W'(SIG_DEPTH);
    lo_sel  = at_edge ? SIG_AW'(SIG_DEPTH) : idx[SIG_AW-1:0];
    hi_sel  = at_edge ? SIG_AW'(SIG_DEPTH) : lo_sel + SIG_AW'(1);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lo3_r   <= SIG_TABLE[lo_sel];
      hi3_r   <= SIG_TABLE[hi_sel];
      frac3_r <= at_edge ? 16'd0 : pos[41:26];
      neg3_r  <= neg2_r;
      da3_r   <= da2_r;
      c3_r    <= c2_r;
    end
  end

  // stage 4: interpolation and sign
  always_comb begin
    iprod = 34'(hi3_r - lo3_r) * 34'(frac3_r) + 34'h8000;
    ssum  = 19'(lo3_r) + 19'(iprod[33:16]);
    smag  = (ssum > 19'(Q16_ONE)) ? Q16_ONE : ssum[16:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_r  <= neg3_r ? (Q16_ONE - smag) : smag;
      da4_r <= da3_r;
      c4_r  <= c3_r;
    end
  end

  // stage 5: probability with guessing floor
  always_comb begin
    one_c = Q16_ONE - 17'(c4_r);
    pprod = 35'(one_c) * 35'(s4_r) + 35'h8000;
    psum  = 20'(c4_r) + 20'(pprod[34:16]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p5_r  <= (psum > 20'(Q16_ONE)) ? Q16_ONE : psum[16:0];
      da5_r <= da4_r;
      c5_r  <= c4_r;
    end
  end

  assign res_valid    = v_r[4];
  assign res.p17      = p5_r;
  assign res.guessing = c5_r;
  assign res.da       = da5_r;

endmodule

/* rtl/irt3pl_core_top_placeholder.sv */
// information back end: slope, square, numerator and final divide
module irt3pl_back
  import irt3pl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        f_valid,
  input  front_res_t  f_res,
  output logic        b_valid,
  output logic [15:0] b_prob,
  output logic [23:0] b_info,
  output logic        b_sat
);

  logic [DIV_LAT-1:0] gv_r;
  logic [16:0]        gp_r  [DIV_LAT];
  logic [31:0]        gda_r [DIV_LAT];
  logic [2:0]         mv_r;
  logic [22:0]        m_r;
  logic [45:0]        msq_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [16:0]        mp_r, sqp_r, nump_r;
  logic [DIV_LAT-1:0] iv_r;
  logic [16:0]        ip_r  [DIV_LAT];

  logic [16:0]          one_c;
  logic [DIV_NUM_W-1:0] g_num;
  logic [INFO_QW-1:0]   g_quot;
  logic                 g_ovf;
  logic [49:0]          mprod;
  logic [DIV_NUM_W-1:0] i_num;
  logic [DIV_DEN_W-1:0] i_den;
  logic [INFO_QW-1:0]   i_quot;
  logic                 i_ovf;
  logic [16:0]          p_end;

  // g = (p - c) / (1 - c), rounded
  always_comb begin
    one_c = Q16_ONE - 17'(f_res.guessing);
    g_num = DIV_NUM_W'({f_res.p17 - 17'(f_res.guessing), 16'd0}) + DIV_NUM_W'(one_c >> 1);
  end

  irt3pl_div u_gdiv (
    .clk  (clk),
    .en   (en),
    .num  (g_num),
    .den  (DIV_DEN_W'(one_c)),
    .quot (g_quot),
    .ovf  (g_ovf)
  );

  // valid bits beside both dividers and the middle stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r <= '0;
      mv_r <= '0;
      iv_r <= '0;
    end else if (en) begin
      gv_r <= {gv_r[DIV_LAT-2:0], f_valid};
      mv_r <= {mv_r[1:0], gv_r[DIV_LAT-1]};
      iv_r <= {iv_r[DIV_LAT-2:0], mv_r[2]};
    end
  end

  // sideband delay beside the slope divider
  always_ff @(posedge clk) begin
    if (en) begin
      gp_r[0]  <= f_res.p17;
      gda_r[0] <= f_res.da;
      for (int j = 1; j < DIV_LAT; j++) begin
        gp_r[j]  <= gp_r[j-1];
        gda_r[j] <= gda_r[j-1];
      end
    end
  end

  // m = da * g, rounded, then m squared, then times (1 - p)
  assign mprod = 50'(gda_r[DIV_LAT-1]) * 50'(g_quot[16:0]) + (50'd1 << 25);
  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= mprod[48:26];
      mp_r   <= gp_r[DIV_LAT-1];
      msq_r  <= 46'(m_r) * 46'(m_r);
      sqp_r  <= mp_r;
      num_r  <= DIV_NUM_W'(63'(msq_r) * 63'(Q16_ONE - sqp_r));
      nump_r <= sqp_r;
    end
  end

  // information = num / (p << 16), rounded
  assign i_num = num_r + (DIV_NUM_W'(nump_r) << 15);
  assign i_den = {nump_r, 16'd0};

  irt3pl_div u_idiv (
    .clk  (clk),
    .en   (en),
    .num  (i_num),
    .den  (i_den),
    .quot (i_quot),
    .ovf  (i_ovf)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ip_r[0] <= nump_r;
      for (int j = 1; j < DIV_LAT; j++) ip_r[j] <= ip_r[j-1];
    end
  end

  // saturation and probability clamp
  assign p_end   = ip_r[DIV_LAT-1];
  assign b_valid = iv_r[DIV_LAT-1];
  assign b_prob  = (p_end == Q16_ONE) ? 16'hFFFF : p_end[15:0];
  assign b_sat   = (p_end == 17'd0) || i_ovf;
  assign b_info  = b_sat ? INFO_MAX : i_quot;

  logic unused_g_ovf;
  assign unused_g_ovf = g_ovf ^ (^g_quot[INFO_QW-1:17]);

endmodule

/* rtl/irt_3pl_probability_information_core.sv */
// top level of the three-parameter logistic probability and information core
//
// usage: requests enter on in_ch (ability, discrimination, difficulty,
// guessing) with valid/ready; each request gives exactly one result on
// out_ch (probability, information, info_saturated), in order.
// the scale register is to be written through cfg_wr_en / cfg_wr_data only
// while idle; the block itself does not enforce this.
// pipeline: 59 register stages, the first loaded at the accepting edge: 5 front
// stages, 25-stage slope divider, 3 multiply stages, 25-stage information
// divider, output register. throughput: one request per cycle while the output
// is not stalled, set by the single pipeline that advances as a whole.
// reset: rst_n low clears all valid bits and loads scale 1.702 (13943).
// stall: while a result waits with out ready low, the whole pipeline holds
// and in ready is low; when the output register is empty or taken, a new
// request is accepted in the same cycle.
module irt_3pl_probability_information_core
  import irt3pl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  irt3pl_in_if.sink   in_ch,
  irt3pl_out_if.source out_ch
);

`include "irt_3pl_probability_information_core_macros.svh"

  logic [15:0] scale_r;
  logic        out_valid_r;
  logic [15:0] prob_r;
  logic [23:0] info_r;
  logic        sat_r;

  logic        en;
  logic        in_acc;
  item_t       item;
  logic        f_valid;
  front_res_t  f_res;
  logic        b_valid;
  logic [15:0] b_prob;
  logic [23:0] b_info;
  logic        b_sat;

  // pipeline advances unless a result is stuck at the output
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_acc      = in_ch.valid && en;

  // scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  assign item.ability        = in_ch.ability;
  assign item.discrimination = in_ch.discrimination;
  assign item.difficulty     = in_ch.difficulty;
  assign item.guessing       = in_ch.guessing;

  irt3pl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_acc),
    .item      (item),
    .scale     (scale_r),
    .res_valid (f_valid),
    .res       (f_res)
  );

  irt3pl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .f_valid (f_valid),
    .f_res   (f_res),
    .b_valid (b_valid),
    .b_prob  (b_prob),
    .b_info  (b_info),
    .b_sat   (b_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prob_r <= b_prob;
      info_r <= b_info;
      sat_r  <= b_sat;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.probability    = prob_r;
  assign out_ch.information    = info_r;
  assign out_ch.info_saturated = sat_r;

  // checks
  `IRT3PL_ASSERT_NOW(a_stall_blocks_in, out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken during output stall")
  `IRT3PL_ASSERT_NOW(a_sat_is_max, out_ch.valid && out_ch.info_saturated, out_ch.information == INFO_MAX, "saturated information not at max")
  `IRT3PL_ASSERT_NOW(a_zero_prob_sat, out_ch.valid && out_ch.probability == 16'd0, out_ch.info_saturated, "zero probability without saturation flag")
  `IRT3PL_ASSERT_NEXT(a_hold_on_stall, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped while stalled")

endmodule
